@@ src/sbcf_pkg.sv @@
`default_nettype none
package sbcf_pkg;

    // Register stages of the limiter outside its divider:
    // difference, magnitude, psi, product, face value.
    localparam int LIM_FIXED_STAGES = 5;

    // Register stages of the flux datapath, the output register included.
    localparam int FLUX_STAGES = 8;

    // Pipeline control that the top level hands to each datapath module.
    typedef struct packed {
        logic en;
    } t_pipe_ctl;

endpackage
`default_nettype wire

@@ src/sbcf_in_if.sv @@
`default_nettype none
interface sbcf_in_if #(
    parameter int VW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] phi_mm;
    logic signed [VW-1:0] phi_m;
    logic signed [VW-1:0] phi_c;
    logic signed [VW-1:0] phi_p;
    logic signed [VW-1:0] phi_pp;
    logic        [VW-2:0] rho_m;
    logic        [VW-2:0] rho_c;
    logic        [VW-2:0] rho_p;
    logic signed [VW-1:0] vel_low_face;
    logic signed [VW-1:0] vel_high_face;
    logic signed [VW-1:0] rhs_in;

    modport source (
        output valid, phi_mm, phi_m, phi_c, phi_p, phi_pp, rho_m, rho_c, rho_p,
               vel_low_face, vel_high_face, rhs_in,
        input  ready
    );
    modport sink (
        input  valid, phi_mm, phi_m, phi_c, phi_p, phi_pp, rho_m, rho_c, rho_p,
               vel_low_face, vel_high_face, rhs_in,
        output ready
    );
endinterface
`default_nettype wire

@@ src/sbcf_out_if.sv @@
`default_nettype none
interface sbcf_out_if #(
    parameter int VW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] rhs_out;
    logic                 saturated;

    modport source (output valid, rhs_out, saturated, input ready);
    modport sink (input valid, rhs_out, saturated, output ready);
endinterface
`default_nettype wire

@@ src/sbcf_cfg_if.sv @@
`default_nettype none
interface sbcf_cfg_if #(
    parameter int VW = 32
);
    logic          valid;
    logic          ready;
    logic [VW-2:0] face_area;

    modport source (output valid, face_area, input ready);
    modport sink (input valid, face_area, output ready);
endinterface
`default_nettype wire

@@ src/sbcf_limiter.sv @@
`default_nettype none
module sbcf_limiter #(
    parameter int VW = 32,
    parameter int F  = 16
) (
    input  wire                   i_clk,
    input  sbcf_pkg::t_pipe_ctl   i_ctl,
    input  wire signed [VW-1:0]   i_num_a,
    input  wire signed [VW-1:0]   i_num_b,
    input  wire signed [VW-1:0]   i_den_a,
    input  wire signed [VW-1:0]   i_den_b,
    input  wire signed [VW-1:0]   i_sup,
    input  wire signed [VW-1:0]   i_sdn,
    output logic signed [VW-1:0]  o_face
);
    localparam int DW = VW + 1;
    localparam int QB = F + 1;
    localparam int PW = F + 2;
    localparam int ND = F + 1;
    localparam int MW = PW + 1 + DW;
    localparam logic [PW-1:0] ONE = PW'(1) << F;
    localparam logic [PW-1:0] TWO = PW'(1) << (F + 1);

    // stage 1: differences
    logic signed [DW-1:0] r1_num, r1_den, r1_diff;
    logic signed [VW-1:0] r1_sup;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_num  <= {i_num_a[VW-1], i_num_a} - {i_num_b[VW-1], i_num_b};
            r1_den  <= {i_den_a[VW-1], i_den_a} - {i_den_b[VW-1], i_den_b};
            r1_diff <= {i_sdn[VW-1], i_sdn} - {i_sup[VW-1], i_sup};
            r1_sup  <= i_sup;
        end
    end

    // stage 2: magnitudes and special cases
    logic [DW-1:0]        r2_n, r2_d;
    logic                 r2_zden, r2_npos, r2_bad;
    logic signed [DW-1:0] r2_diff;
    logic signed [VW-1:0] r2_sup;
    logic [DW-1:0]        n_n, n_d;
    logic                 n_nzero;

    always_comb begin
        n_n     = r1_num[DW-1] ? DW'(-r1_num) : DW'(r1_num);
        n_d     = r1_den[DW-1] ? DW'(-r1_den) : DW'(r1_den);
        n_nzero = (r1_num == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r2_n    <= n_n;
            r2_d    <= n_d;
            r2_zden <= (r1_den == '0);
            r2_npos <= !r1_num[DW-1] && !n_nzero;
            r2_bad  <= n_nzero || (r1_num[DW-1] != r1_den[DW-1]);
            r2_diff <= r1_diff;
            r2_sup  <= r1_sup;
        end
    end

    // divider: one quotient bit per stage
    logic [DW-1:0]        r_rem  [ND];
    logic [DW-1:0]        r_dv   [ND];
    logic [QB-1:0]        r_q    [ND];
    logic                 r_zden [ND];
    logic                 r_npos [ND];
    logic                 r_bad  [ND];
    logic                 r_big  [ND];
    logic signed [DW-1:0] r_ddif [ND];
    logic signed [VW-1:0] r_dsup [ND];

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [DW:0] t, sub;
        logic        ge;
        if (k == 0) begin : g_first
            always_comb begin
                t   = {1'b0, r2_n};
                ge  = t >= {1'b0, r2_d};
                sub = t - {1'b0, r2_d};
            end
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[k]  <= ge ? sub[DW-1:0] : t[DW-1:0];
                    r_dv[k]   <= r2_d;
                    r_q[k]    <= {{(QB-1){1'b0}}, ge};
                    r_zden[k] <= r2_zden;
                    r_npos[k] <= r2_npos;
                    r_bad[k]  <= r2_bad;
                    r_big[k]  <= {1'b0, r2_n} >= {r2_d, 1'b0};
                    r_ddif[k] <= r2_diff;
                    r_dsup[k] <= r2_sup;
                end
            end
        end else begin : g_step
            always_comb begin
                t   = {r_rem[k-1], 1'b0};
                ge  = t >= {1'b0, r_dv[k-1]};
                sub = t - {1'b0, r_dv[k-1]};
            end
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[k]  <= ge ? sub[DW-1:0] : t[DW-1:0];
                    r_dv[k]   <= r_dv[k-1];
                    r_q[k]    <= {r_q[k-1][QB-2:0], ge};
                    r_zden[k] <= r_zden[k-1];
                    r_npos[k] <= r_npos[k-1];
                    r_bad[k]  <= r_bad[k-1];
                    r_big[k]  <= r_big[k-1];
                    r_ddif[k] <= r_ddif[k-1];
                    r_dsup[k] <= r_dsup[k-1];
                end
            end
        end
    end

    // psi stage
    logic [PW-1:0]        r_psi, n_psi, n_two, n_a, n_b;
    logic signed [DW-1:0] r_pdif;
    logic signed [VW-1:0] r_psup;

    always_comb begin
        n_two = {r_q[ND-1], 1'b0};
        n_a   = (n_two < ONE) ? n_two : ONE;
        n_b   = {1'b0, r_q[ND-1]};
        priority if (r_zden[ND-1]) begin
            n_psi = r_npos[ND-1] ? TWO : '0;
        end else if (r_bad[ND-1]) begin
            n_psi = '0;
        end else if (r_big[ND-1]) begin
            n_psi = TWO;
        end else begin
            n_psi = (n_a > n_b) ? n_a : n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_psi  <= n_psi;
            r_pdif <= r_ddif[ND-1];
            r_psup <= r_dsup[ND-1];
        end
    end

    // product stage
    logic signed [MW-1:0] r_prod;
    logic signed [VW-1:0] r_msup;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= MW'($signed({1'b0, r_psi}) * r_pdif);
            r_msup <= r_psup;
        end
    end

    // face stage: floor shift, then add the upwind value
    logic signed [MW-1:0] n_sh, n_face;

    always_comb begin
        n_sh   = r_prod >>> (F + 1);
        n_face = n_sh + {{(MW-VW){r_msup[VW-1]}}, r_msup};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_face <= n_face[VW-1:0];
        end
    end
endmodule
`default_nettype wire

@@ src/sbcf_flux.sv @@
`default_nettype none
module sbcf_flux #(
    parameter int VW = 32,
    parameter int F  = 16
) (
    input  wire                   i_clk,
    input  sbcf_pkg::t_pipe_ctl   i_ctl,
    input  wire        [VW-2:0]   i_area,
    input  wire signed [VW-1:0]   i_face_hi,
    input  wire signed [VW-1:0]   i_face_lo,
    input  wire signed [VW-1:0]   i_vel_hi,
    input  wire signed [VW-1:0]   i_vel_lo,
    input  wire        [VW-2:0]   i_rho_m,
    input  wire        [VW-2:0]   i_rho_c,
    input  wire        [VW-2:0]   i_rho_p,
    input  wire signed [VW-1:0]   i_rhs,
    output logic signed [VW-1:0]  o_rhs_out,
    output logic                  o_sat
);
    localparam int W2 = 2 * VW;
    localparam int W4 = 4 * VW;
    localparam int SH = 3 * F + 1;
    localparam int QW = W4 - SH;
    localparam int NR = 6;

    logic signed [VW-1:0] r_rhs [NR];

    // X1: magnitudes, signs, density sums
    logic [VW-1:0] r1_fm_hi, r1_fm_lo, r1_vm_hi, r1_vm_lo, r1_rs_hi, r1_rs_lo;
    logic          r1_neg_hi, r1_neg_lo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_fm_hi  <= i_face_hi[VW-1] ? VW'(~i_face_hi + 1'b1) : VW'(i_face_hi);
            r1_fm_lo  <= i_face_lo[VW-1] ? VW'(~i_face_lo + 1'b1) : VW'(i_face_lo);
            r1_vm_hi  <= i_vel_hi[VW-1] ? VW'(~i_vel_hi + 1'b1) : VW'(i_vel_hi);
            r1_vm_lo  <= i_vel_lo[VW-1] ? VW'(~i_vel_lo + 1'b1) : VW'(i_vel_lo);
            r1_neg_hi <= i_face_hi[VW-1] ^ i_vel_hi[VW-1];
            r1_neg_lo <= i_face_lo[VW-1] ^ i_vel_lo[VW-1];
            r1_rs_hi  <= {1'b0, i_rho_c} + {1'b0, i_rho_p};
            r1_rs_lo  <= {1'b0, i_rho_c} + {1'b0, i_rho_m};
            r_rhs[0]  <= i_rhs;
        end
    end

    // X2: rho*face and vel*area
    logic [W2-1:0] r2_rf_hi, r2_rf_lo, r2_va_hi, r2_va_lo;
    logic          r2_neg_hi, r2_neg_lo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r2_rf_hi  <= r1_rs_hi * r1_fm_hi;
            r2_rf_lo  <= r1_rs_lo * r1_fm_lo;
            r2_va_hi  <= W2'(r1_vm_hi * i_area);
            r2_va_lo  <= W2'(r1_vm_lo * i_area);
            r2_neg_hi <= r1_neg_hi;
            r2_neg_lo <= r1_neg_lo;
            r_rhs[1]  <= r_rhs[0];
        end
    end

    // X3: half-word partial products
    logic [W2-1:0] r3_hi [4];
    logic [W2-1:0] r3_lo [4];
    logic          r3_neg_hi, r3_neg_lo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r3_hi[0]  <= r2_rf_hi[VW-1:0]  * r2_va_hi[VW-1:0];
            r3_hi[1]  <= r2_rf_hi[VW-1:0]  * r2_va_hi[W2-1:VW];
            r3_hi[2]  <= r2_rf_hi[W2-1:VW] * r2_va_hi[VW-1:0];
            r3_hi[3]  <= r2_rf_hi[W2-1:VW] * r2_va_hi[W2-1:VW];
            r3_lo[0]  <= r2_rf_lo[VW-1:0]  * r2_va_lo[VW-1:0];
            r3_lo[1]  <= r2_rf_lo[VW-1:0]  * r2_va_lo[W2-1:VW];
            r3_lo[2]  <= r2_rf_lo[W2-1:VW] * r2_va_lo[VW-1:0];
            r3_lo[3]  <= r2_rf_lo[W2-1:VW] * r2_va_lo[W2-1:VW];
            r3_neg_hi <= r2_neg_hi;
            r3_neg_lo <= r2_neg_lo;
            r_rhs[2]  <= r_rhs[1];
        end
    end

    // X4: assemble full products
    logic [W4-1:0] r4_p_hi, r4_p_lo;
    logic          r4_neg_hi, r4_neg_lo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r4_p_hi <= {{W2{1'b0}}, r3_hi[0]} + {{VW{1'b0}}, r3_hi[1], {VW{1'b0}}}
                     + {{VW{1'b0}}, r3_hi[2], {VW{1'b0}}} + {r3_hi[3], {W2{1'b0}}};
            r4_p_lo <= {{W2{1'b0}}, r3_lo[0]} + {{VW{1'b0}}, r3_lo[1], {VW{1'b0}}}
                     + {{VW{1'b0}}, r3_lo[2], {VW{1'b0}}} + {r3_lo[3], {W2{1'b0}}};
            r4_neg_hi <= r3_neg_hi;
            r4_neg_lo <= r3_neg_lo;
            r_rhs[3]  <= r_rhs[2];
        end
    end

    // X5: apply signs
    logic [W4-1:0] r5_t_hi, r5_t_lo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r5_t_hi  <= r4_neg_hi ? (~r4_p_hi + 1'b1) : r4_p_hi;
            r5_t_lo  <= r4_neg_lo ? (~r4_p_lo + 1'b1) : r4_p_lo;
            r_rhs[4] <= r_rhs[3];
        end
    end

    // X6: flux difference, exact
    logic signed [W4-1:0] r6_d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r6_d     <= $signed(r5_t_hi - r5_t_lo);
            r_rhs[5] <= r_rhs[4];
        end
    end

    // X7: round down to the fraction, add rhs
    logic signed [W4-1:0] n_q;
    logic signed [QW:0]   r7_s;

    always_comb begin
        n_q = r6_d >>> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r7_s <= {n_q[QW-1], n_q[QW-1:0]}
                  + {{(QW+1-VW){r_rhs[NR-1][VW-1]}}, r_rhs[NR-1]};
        end
    end

    // X8: clamp to the value range
    localparam logic signed [QW:0] VMAX = (QW+1)'({1'b0, {(VW-1){1'b1}}});
    localparam logic signed [QW:0] VMIN = ~VMAX;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            priority if (r7_s > VMAX) begin
                o_rhs_out <= VMAX[VW-1:0];
                o_sat     <= 1'b1;
            end else if (r7_s < VMIN) begin
                o_rhs_out <= VMIN[VW-1:0];
                o_sat     <= 1'b1;
            end else begin
                o_rhs_out <= r7_s[VW-1:0];
                o_sat     <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ src/superbee_convection_flux.sv @@
// Superbee flux-limited upwind convection, one cell along one axis.
// Channels: i_in carries a five-point scalar stencil, three densities, the
// two face velocities and the incoming rhs; o_out returns rhs_out and the
// saturated flag, one result per input transfer, in order. i_cfg writes the
// face area (unsigned Q15.16); write it only while the pipeline is empty.
// Throughput: one item per cycle while o_out is not stalled. Results pass
// through the input register, the divider that forms the limiter ratio
// one quotient bit per stage (FRAC_BITS + 1 stages), the limiter product,
// the split 64x64 flux product and the final round and clamp.
// Reset clears every valid bit and sets the face area to 1.0; payload
// registers keep whatever they held.
// A stall at o_out freezes the whole pipeline in place: i_in.ready drops in
// the same cycle, nothing is lost or repeated, and bubbles travel as plain
// invalid stages.
`default_nettype none
module superbee_convection_flux #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sbcf_in_if.sink    i_in,
    sbcf_out_if.source o_out,
    sbcf_cfg_if.sink   i_cfg
);
    localparam int VW  = VALUE_WIDTH;
    localparam int LD  = sbcf_pkg::LIM_FIXED_STAGES + FRAC_BITS + 1;
    localparam int LAT = 1 + LD + sbcf_pkg::FLUX_STAGES;
    localparam int SW  = 3 * (VW - 1) + 3 * VW;

    sbcf_pkg::t_pipe_ctl ctl;
    logic [LAT-1:0]      r_vld;
    logic [VW-2:0]       r_area;

    // Advance whenever the output register is free or being emptied.
    assign ctl.en      = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = ctl.en;
    assign o_out.valid = r_vld[LAT-1];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_area <= (VW-1)'(1) << FRAC_BITS;
        end else begin
            if (ctl.en) begin
                r_vld <= {r_vld[LAT-2:0], i_in.valid};
            end
            if (i_cfg.valid) begin
                r_area <= i_cfg.face_area;
            end
        end
    end

    // Input register.
    logic signed [VW-1:0] r0_pmm, r0_pm, r0_pc, r0_pp, r0_ppp, r0_ulo, r0_uhi, r0_rhs;
    logic        [VW-2:0] r0_rm, r0_rc, r0_rp;

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r0_pmm <= i_in.phi_mm;
            r0_pm  <= i_in.phi_m;
            r0_pc  <= i_in.phi_c;
            r0_pp  <= i_in.phi_p;
            r0_ppp <= i_in.phi_pp;
            r0_rm  <= i_in.rho_m;
            r0_rc  <= i_in.rho_c;
            r0_rp  <= i_in.rho_p;
            r0_ulo <= i_in.vel_low_face;
            r0_uhi <= i_in.vel_high_face;
            r0_rhs <= i_in.rhs_in;
        end
    end

    // Pick the upwind stencil at each face by the sign of its velocity;
    // a velocity of zero takes the same form as a negative one.
    logic pos_lo, pos_hi;
    assign pos_lo = !r0_ulo[VW-1] && (r0_ulo != '0);
    assign pos_hi = !r0_uhi[VW-1] && (r0_uhi != '0);

    logic signed [VW-1:0] face_lo, face_hi;

    sbcf_limiter #(.VW(VW), .F(FRAC_BITS)) u_lim_lo (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_num_a (pos_lo ? r0_pm : r0_pp),
        .i_num_b (pos_lo ? r0_pmm : r0_pc),
        .i_den_a (r0_pc),
        .i_den_b (r0_pm),
        .i_sup   (pos_lo ? r0_pm : r0_pc),
        .i_sdn   (pos_lo ? r0_pc : r0_pm),
        .o_face  (face_lo)
    );

    sbcf_limiter #(.VW(VW), .F(FRAC_BITS)) u_lim_hi (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_num_a (pos_hi ? r0_pc : r0_ppp),
        .i_num_b (pos_hi ? r0_pm : r0_pp),
        .i_den_a (r0_pp),
        .i_den_b (r0_pc),
        .i_sup   (pos_hi ? r0_pc : r0_pp),
        .i_sdn   (pos_hi ? r0_pp : r0_pc),
        .o_face  (face_hi)
    );

    // Delay densities, velocities and rhs alongside the limiters.
    logic [SW-1:0] r_side [LD];

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_side[0] <= {r0_rm, r0_rc, r0_rp, r0_ulo, r0_uhi, r0_rhs};
            for (int k = 1; k < LD; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic        [VW-2:0] d_rm, d_rc, d_rp;
    logic signed [VW-1:0] d_ulo, d_uhi, d_rhs;
    assign {d_rm, d_rc, d_rp, d_ulo, d_uhi, d_rhs} = r_side[LD-1];

    sbcf_flux #(.VW(VW), .F(FRAC_BITS)) u_flux (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_area    (r_area),
        .i_face_hi (face_hi),
        .i_face_lo (face_lo),
        .i_vel_hi  (d_uhi),
        .i_vel_lo  (d_ulo),
        .i_rho_m   (d_rm),
        .i_rho_c   (d_rc),
        .i_rho_p   (d_rp),
        .i_rhs     (d_rhs),
        .o_rhs_out (o_out.rhs_out),
        .o_sat     (o_out.saturated)
    );
endmodule
`default_nettype wire
